FILE: design/mjtfc_pkg.sv
package mjtfc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TICK_BITS = 20;
   localparam int S_BITS    = 16;

   localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

   // thresholds, squared, in Q.(2*FRAC_BITS)
   localparam longint EPS_ORIGIN = ((64'sd1 <<< FRAC_BITS) + 64'sd5000) / 64'sd10000;
   localparam longint VEL_TRIP   = ((64'sd3 <<< FRAC_BITS) + 64'sd1) / 64'sd2;
   localparam longint HOLD_POS   = ((64'sd2 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
   localparam longint HOLD_VEL   = ((64'sd5 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
   localparam logic [39:0] EPS2      = 40'(EPS_ORIGIN * EPS_ORIGIN);
   localparam logic [39:0] VTRIP2    = 40'(VEL_TRIP * VEL_TRIP);
   localparam logic [39:0] HPOS2     = 40'(HOLD_POS * HOLD_POS);
   localparam logic [39:0] HVEL2     = 40'(HOLD_VEL * HOLD_VEL);

   typedef enum logic [2:0] {
      REG_TARGET_X  = 3'd0,
      REG_TARGET_Y  = 3'd1,
      REG_MOVE      = 3'd2,
      REG_FADE      = 3'd3,
      REG_STIFFNESS = 3'd4,
      REG_DAMPING   = 3'd5,
      REG_LIMIT     = 3'd6,
      REG_HOLD      = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SDIV,
      ST_POW,
      ST_AXIS,
      ST_FDIV,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [16:0] target_x;
      logic [16:0] target_y;
      logic [19:0] move_ticks;
      logic [15:0] fade_ticks;
      logic [15:0] stiffness;
      logic [15:0] damping;
      logic [14:0] force_limit;
      logic [19:0] hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic        busy;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

FILE: design/minjerk_tracking_force_control.sv
// channel  dir  beat                               
// req_     in   tdata {vel_y,vel_x,pos_y,pos_x}, tuser restart
// rsp_     out  tdata {force_y,force_x}, tuser {at_target,tripped}
// csr_     in   index 0..7, one register write per enabled cycle
// a sample passes from acceptance to its result beat through the norms, the move
// ratio on the shared restoring divider, the blend powers, each axis in turn, then
// finish and output; a zero move time skips divide and powers, a trip skips all
// force work, and each fading axis adds a divide on the shared divider
// all products go through one registered multiplier; req_tready is low from
// acceptance until the result beat is taken; reset is synchronous
module minjerk_tracking_force_control (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // pos_x, pos_y, vel_x, vel_y
   input  logic        req_tuser,  // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // force_x, force_y
   output logic [1:0]  rsp_tuser,  // tripped, at_target
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   import mjtfc_pkg::*;

   state_type state_ff, state_in;
   cfg_type   cfg_ff, cfg_in;

   logic signed [17:0] px_ff, py_ff, vx_ff, vy_ff, sx_ff, sy_ff;
   logic               rst_ff;
   logic [TICK_BITS-1:0] elapsed_ff, elapsed_in, band_ff, band_in;
   logic               inband_ff, inband_in, trip_ff, trip_in;
   logic [4:0]         step_ff, step_in;
   logic               axis_ff, axis_in;
   logic [16:0]        s_ff, s_in, pw_ff, pw_in;
   logic signed [24:0] p_ff, p_in;
   logic signed [71:0] acc_ff, acc_in, acc2_ff, acc2_in;
   logic signed [35:0] xd_ff, xd_in;
   logic signed [15:0] fx_ff, fx_in, fy_ff, fy_in;
   logic               at_ff, at_in;

   logic signed [35:0] ma, mb;
   logic signed [71:0] prod;
   div_req_type        dreq;
   div_rsp_type        drsp;

   mjtfc_mac u_mac (.clock(clock), .op_a(ma), .op_b(mb), .product(prod));
   mjtfc_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic req_fire, rsp_fire;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // axis operands
   logic signed [17:0] cur_s, cur_p, cur_v;
   logic [16:0]        cur_t;
   logic [TICK_BITS-1:0] e_clip;
   logic signed [71:0] mag;
   logic signed [71:0] clamp_src;
   logic               neg;
   logic signed [71:0] floored, lim_p;
   logic signed [15:0] fclamp;

   always_comb begin
      cur_s  = axis_ff ? sy_ff : sx_ff;
      cur_p  = axis_ff ? py_ff : px_ff;
      cur_v  = axis_ff ? vy_ff : vx_ff;
      cur_t  = axis_ff ? cfg_ff.target_y : cfg_ff.target_x;
      e_clip = (elapsed_ff < cfg_ff.move_ticks) ? elapsed_ff : cfg_ff.move_ticks;
      neg    = acc_ff[71];
      mag    = neg ? -acc_ff : acc_ff;
      clamp_src = (state_ff == ST_FDIV)
                  ? (acc2_ff[71] ? -72'(drsp.quotient) : 72'(drsp.quotient))
                  : acc_ff;
      floored = clamp_src >>> (FRAC_BITS - 2);
      lim_p  = 72'(cfg_ff.force_limit);
      if (floored > lim_p)       fclamp = 16'(cfg_ff.force_limit);
      else if (floored < -lim_p) fclamp = -16'(cfg_ff.force_limit);
      else                       fclamp = floored[15:0];
   end

   // multiplier operand select per step
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (state_ff)
         ST_CHECK: begin
            unique case (step_ff)
               5'd0: begin ma = 36'(px_ff); mb = 36'(px_ff); end
               5'd1: begin ma = 36'(py_ff); mb = 36'(py_ff); end
               5'd2: begin ma = 36'(vx_ff); mb = 36'(vx_ff); end
               5'd3: begin ma = 36'(vy_ff); mb = 36'(vy_ff); end
               5'd4: begin
                  ma = 36'(signed'({1'b0, cfg_ff.target_x})) - 36'(px_ff);
                  mb = ma;
               end
               5'd5: begin
                  ma = 36'(signed'({1'b0, cfg_ff.target_y})) - 36'(py_ff);
                  mb = ma;
               end
               default: ;
            endcase
         end
         ST_POW: begin
            ma = 36'(signed'({1'b0, pw_ff}));
            mb = 36'(signed'({1'b0, s_ff}));
         end
         ST_AXIS: begin
            unique case (step_ff)
               5'd0: begin
                  ma = 36'(signed'({1'b0, cur_t})) - 36'(cur_s);
                  mb = 36'(p_ff);
               end
               5'd2: begin
                  ma = 36'(signed'({1'b0, cfg_ff.stiffness})) + 36'sd64;
                  mb = xd_ff - 36'(cur_p);
               end
               5'd3: begin
                  ma = 36'(signed'({1'b0, cfg_ff.damping}));
                  mb = 36'(cur_v);
               end
               5'd5: begin
                  ma = 36'(mag);
                  mb = 36'(elapsed_ff);
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   logic [39:0] pos2, vel2, d2;
   logic [39:0] sq_ff [0:5];
   logic [39:0] sq_in [0:5];

   always_comb begin
      pos2 = sq_ff[0] + sq_ff[1];
      vel2 = sq_ff[2] + sq_ff[3];
      d2   = sq_ff[4] + sq_ff[5];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_CHECK;
         ST_CHECK: if (step_ff == 5'd7) begin
            if (trip_in) state_in = ST_FINISH;
            else if (cfg_ff.move_ticks == '0) state_in = ST_AXIS;
            else state_in = ST_SDIV;
         end
         ST_SDIV:  if (drsp.done) state_in = ST_POW;
         ST_POW:   if (step_ff == 5'd9) state_in = ST_AXIS;
         ST_AXIS: begin
            if (step_ff == 5'd6) state_in = ST_FDIV;
            else if (step_ff == 5'd5 && axis_ff
                     && elapsed_ff >= TICK_BITS'(cfg_ff.fade_ticks))
               state_in = ST_FINISH;
         end
         ST_FDIV:  if (drsp.done && axis_ff) state_in = ST_FINISH;
                   else if (drsp.done) state_in = ST_AXIS;
         ST_FINISH: state_in = ST_OUT;
         ST_OUT:   if (rsp_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cfg_in     = cfg_ff;
      elapsed_in = elapsed_ff;
      band_in    = band_ff;
      inband_in  = inband_ff;
      trip_in    = trip_ff;
      step_in    = step_ff + 5'd1;
      axis_in    = axis_ff;
      s_in       = s_ff;
      pw_in      = pw_ff;
      p_in       = p_ff;
      acc_in     = acc_ff;
      acc2_in    = acc2_ff;
      xd_in      = xd_ff;
      fx_in      = fx_ff;
      fy_in      = fy_ff;
      at_in      = at_ff;
      dreq       = '0;
      for (int i = 0; i < 6; i++) sq_in[i] = sq_ff[i];

      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_TARGET_X:  cfg_in.target_x    = csr_wdata[16:0];
            REG_TARGET_Y:  cfg_in.target_y    = csr_wdata[16:0];
            REG_MOVE:      cfg_in.move_ticks  = csr_wdata;
            REG_FADE:      cfg_in.fade_ticks  = csr_wdata[15:0];
            REG_STIFFNESS: cfg_in.stiffness   = csr_wdata[15:0];
            REG_DAMPING:   cfg_in.damping     = csr_wdata[15:0];
            REG_LIMIT:     cfg_in.force_limit = csr_wdata[14:0];
            REG_HOLD:      cfg_in.hold_ticks  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            axis_in = 1'b0;
            fx_in   = '0;
            fy_in   = '0;
            if (req_fire && req_tuser) begin
               elapsed_in = '0;
               band_in    = '0;
               inband_in  = 1'b0;
               trip_in    = 1'b0;
            end
         end
         ST_CHECK: begin
            // products land in the cycle after issue
            if (step_ff >= 5'd1 && step_ff <= 5'd6)
               sq_in[3'(step_ff - 5'd1)] = prod[39:0];
            if (step_ff == 5'd7) begin
               step_in = '0;
               if (!trip_ff && (pos2 < EPS2 || vel2 > VTRIP2)) trip_in = 1'b1;
               if (!(!trip_ff && (pos2 < EPS2 || vel2 > VTRIP2))
                   && cfg_ff.move_ticks == '0)
                  p_in = 25'sd65536;
               if (!(!trip_ff && (pos2 < EPS2 || vel2 > VTRIP2))
                   && cfg_ff.move_ticks != '0) begin
                  dreq.start    = 1'b1;
                  dreq.dividend = 64'(e_clip) << S_BITS;
                  dreq.divisor  = 32'(cfg_ff.move_ticks);
               end
            end
         end
         ST_SDIV: begin
            step_in = '0;
            if (drsp.done) begin
               s_in  = drsp.quotient[16:0];
               pw_in = drsp.quotient[16:0];
               p_in  = '0;
            end
         end
         ST_POW: begin
            // odd steps collect s^2..s^6; only s^3..s^5 enter the blend
            if (step_ff[0]) begin
               pw_in = prod[32:16];
               unique case (step_ff)
                  5'd3: p_in = p_ff + 25'(10 * 25'(prod[32:16]));
                  5'd5: p_in = p_ff - 25'(15 * 25'(prod[32:16]));
                  5'd7: p_in = p_ff + 25'(6 * 25'(prod[32:16]));
                  default: ;
               endcase
            end
            if (step_ff == 5'd9) step_in = '0;
         end
         ST_AXIS: begin
            unique case (step_ff)
               5'd1: xd_in = 36'(cur_s) + 36'(prod >>> S_BITS);
               5'd3: acc_in = prod;
               5'd4: acc_in = acc_ff - prod;
               5'd5: begin
                  if (elapsed_ff >= TICK_BITS'(cfg_ff.fade_ticks)) begin
                     step_in = '0;
                     if (axis_ff) fy_in = fclamp; else fx_in = fclamp;
                     axis_in = 1'b1;
                  end
               end
               5'd6: begin
                  step_in       = '0;
                  acc2_in       = acc_ff;
                  dreq.start    = 1'b1;
                  dreq.dividend = 64'(prod);
                  dreq.divisor  = 32'(cfg_ff.fade_ticks);
               end
               default: ;
            endcase
         end
         ST_FDIV: begin
            step_in = '0;
            if (drsp.done) begin
               if (axis_ff) fy_in = fclamp; else fx_in = fclamp;
               axis_in = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!trip_ff && d2 <= HPOS2 && vel2 <= HVEL2) begin
               if (!inband_ff) begin
                  inband_in = 1'b1;
                  band_in   = '0;
               end else begin
                  if (band_ff < TICK_MAX) band_in = band_ff + TICK_BITS'(1);
                  at_in = ((band_ff < TICK_MAX) ? band_ff + TICK_BITS'(1) : band_ff)
                          >= cfg_ff.hold_ticks;
               end
            end else begin
               inband_in = 1'b0;
               band_in   = '0;
            end
            if (elapsed_ff < TICK_MAX) elapsed_in = elapsed_ff + TICK_BITS'(1);
         end
         ST_OUT: begin
            if (rsp_fire) at_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cfg_ff     <= '{target_x: 17'd20972, target_y: 17'd7864, move_ticks: 20'd2000,
                         fade_ticks: 16'd500, stiffness: 16'd6400, damping: 16'd400,
                         force_limit: 15'd3840, hold_ticks: 20'd500};
         elapsed_ff <= '0;
         band_ff    <= '0;
         inband_ff  <= 1'b0;
         trip_ff    <= 1'b0;
         sx_ff      <= '0;
         sy_ff      <= '0;
         step_ff    <= '0;
         axis_ff    <= 1'b0;
         at_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cfg_ff     <= cfg_in;
         elapsed_ff <= elapsed_in;
         band_ff    <= band_in;
         inband_ff  <= inband_in;
         trip_ff    <= trip_in;
         step_ff    <= step_in;
         axis_ff    <= axis_in;
         at_ff      <= at_in;
         if (req_fire && req_tuser) begin
            sx_ff <= signed'(req_tdata[17:0]);
            sy_ff <= signed'(req_tdata[35:18]);
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      pw_ff   <= pw_in;
      p_ff    <= p_in;
      acc_ff  <= acc_in;
      acc2_ff <= acc2_in;
      xd_ff   <= xd_in;
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
      for (int i = 0; i < 6; i++) sq_ff[i] <= sq_in[i];
      if (req_fire) begin
         px_ff  <= signed'(req_tdata[17:0]);
         py_ff  <= signed'(req_tdata[35:18]);
         vx_ff  <= signed'(req_tdata[53:36]);
         vy_ff  <= signed'(req_tdata[71:54]);
         rst_ff <= req_tuser;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {fy_ff, fx_ff};
   assign rsp_tuser  = {at_ff, trip_ff};

   property p_trip_zero;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0);
   endproperty
   a_trip_zero: assert property (p_trip_zero) else $error("force while tripped");

   property p_restart_clears;
      @(posedge clock) disable iff (reset)
         (req_fire && req_tuser) |=> (elapsed_ff == '0 && !trip_ff && rst_ff);
   endproperty
   a_restart_clears: assert property (p_restart_clears) else $error("restart lost");

   property p_no_overlap;
      @(posedge clock) disable iff (reset)
         rsp_tvalid |-> !req_tready;
   endproperty
   a_no_overlap: assert property (p_no_overlap) else $error("ready while result held");

endmodule

FILE: design/mjtfc_div.sv
module mjtfc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  mjtfc_pkg::div_req_type req,
   output mjtfc_pkg::div_rsp_type rsp
);
   import mjtfc_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;
   logic [33:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.busy     = busy_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: design/mjtfc_mac.sv
module mjtfc_mac (
   input  logic               clock,
   input  logic signed [35:0] op_a,
   input  logic signed [35:0] op_b,
   output logic signed [71:0] product
);
   import mjtfc_pkg::*;

   logic signed [71:0] prod_ff, prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule
